[hdl/assert_macros.svh]
// Assertion macros used by the top level of the Z80 ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[hdl/zalu_pkg.sv]
// Package with the command codes, request and result types and flag helpers of the Z80 ALU.
`default_nettype none
package zalu_pkg;

  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_OR    = 5'd5;
  localparam logic [4:0] CMD_XOR   = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC   = 5'd8;
  localparam logic [4:0] CMD_DEC   = 5'd9;
  localparam logic [4:0] CMD_RLCA  = 5'd10;
  localparam logic [4:0] CMD_RLA   = 5'd11;
  localparam logic [4:0] CMD_RRCA  = 5'd12;
  localparam logic [4:0] CMD_RRA   = 5'd13;
  localparam logic [4:0] CMD_RLC   = 5'd14;
  localparam logic [4:0] CMD_RL    = 5'd15;
  localparam logic [4:0] CMD_RRC   = 5'd16;
  localparam logic [4:0] CMD_RR    = 5'd17;
  localparam logic [4:0] CMD_SLA   = 5'd18;
  localparam logic [4:0] CMD_SRA   = 5'd19;
  localparam logic [4:0] CMD_SRL   = 5'd20;
  localparam logic [4:0] CMD_BIT   = 5'd21;
  localparam logic [4:0] CMD_SET   = 5'd22;
  localparam logic [4:0] CMD_RES   = 5'd23;
  localparam logic [4:0] CMD_CPL   = 5'd24;
  localparam logic [4:0] CMD_ADD16 = 5'd25;
  localparam logic [4:0] CMD_SBC16 = 5'd26;

  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [7:0]  flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  flags;
  } alu_res_t;

  // Bits 5 and 3 of the flag byte are always produced as zero.
  function automatic logic [7:0] pack_flags(input logic s, input logic z, input logic h,
                                            input logic pv, input logic n, input logic c);
    pack_flags = {s, z, 1'b0, h, 1'b0, pv, n, c};
  endfunction

  function automatic logic [7:0] shift_flags(input logic [7:0] r, input logic c);
    shift_flags = pack_flags(r[7], r == 8'h00, 1'b0, ~^r, 1'b0, c);
  endfunction

endpackage
`default_nettype wire

[hdl/z80_alu_with_flags.sv]
// Top level of the Z80 ALU: request register, datapath and result register.
`default_nettype none
`include "assert_macros.svh"
// The unit takes one request in every clock cycle and never raises busy. The edge that
// accepts a request loads it into the request register, and the next edge loads the
// result register after a single pass through the datapath. The result is then on
// result_value and flags_out, marked by done, for exactly one cycle. The receiver
// cannot hold results off, so it must take each one in the cycle done is high.
module z80_alu_with_flags (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [4:0]  command,
  input  wire  [15:0] operand_a,
  input  wire  [15:0] operand_b,
  input  wire  [2:0]  bit_index,
  input  wire  [7:0]  flags_in,
  output logic        done,
  output logic [15:0] result_value,
  output logic [7:0]  flags_out
);

  zalu_pkg::alu_req_t req;
  zalu_pkg::alu_res_t res_next;
  logic               req_valid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      req_valid <= start;
      done      <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req.command   <= command;
      req.operand_a <= operand_a;
      req.operand_b <= operand_b;
      req.bit_index <= bit_index;
      req.flags_in  <= flags_in;
    end
    if (req_valid) begin
      result_value <= res_next.value;
      flags_out    <= res_next.flags;
    end
  end

  zalu_core u_core (
    .req (req),
    .res (res_next)
  );

  `ASSERT_ALWAYS(a_never_busy, clk, !busy)
  `ASSERT_RST(a_done_follows_start, clk, rst, start |-> ##2 done)
  `ASSERT_RST(a_no_spurious_done, clk, rst, !start |-> ##2 !done)
  `ASSERT_RST(a_cp_keeps_target, clk, rst,
    (start && (command == zalu_pkg::CMD_CP || command == zalu_pkg::CMD_BIT))
      |-> ##2 (result_value == $past(operand_a, 2)))
  `ASSERT_RST(a_set_res_keep_flags, clk, rst,
    (start && (command == zalu_pkg::CMD_SET || command == zalu_pkg::CMD_RES))
      |-> ##2 (flags_out == $past(flags_in, 2)))

endmodule
`default_nettype wire

[hdl/zalu_core.sv]
// Combinational datapath of the Z80 ALU: arithmetic, logic, rotates, bit operations and flags.
`default_nettype none
module zalu_core (
  input  wire zalu_pkg::alu_req_t req,
  output zalu_pkg::alu_res_t      res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  f;
  logic        cin;
  logic [8:0]  sum8;
  logic [8:0]  dif8;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  mask8;
  logic [16:0] sum16;
  logic [16:0] dif16;
  logic [7:0]  r8;

  assign a     = req.operand_a[7:0];
  assign b     = req.operand_b[7:0];
  assign f     = req.flags_in;
  assign cin   = req.flags_in[0];
  assign sum8  = {1'b0, a} + {1'b0, b} + {8'h00, (req.command == zalu_pkg::CMD_ADC) & cin};
  assign dif8  = {1'b0, a} - {1'b0, b} - {8'h00, (req.command == zalu_pkg::CMD_SBC) & cin};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;
  assign mask8 = 8'd1 << req.bit_index;
  assign sum16 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign dif16 = {1'b0, req.operand_a} - {1'b0, req.operand_b} - {16'h0000, cin};

  always_comb begin
    r8        = 8'h00;
    res.value = req.operand_a;
    res.flags = f;
    unique case (req.command)
      zalu_pkg::CMD_ADD, zalu_pkg::CMD_ADC: begin
        res.value = {8'h00, sum8[7:0]};
        res.flags = zalu_pkg::pack_flags(sum8[7], sum8[7:0] == 8'h00, a[4] ^ b[4] ^ sum8[4],
                                         ~(a[7] ^ b[7]) & (b[7] ^ sum8[7]), 1'b0, sum8[8]);
      end
      zalu_pkg::CMD_SUB, zalu_pkg::CMD_SBC, zalu_pkg::CMD_CP: begin
        if (req.command != zalu_pkg::CMD_CP) begin
          res.value = {8'h00, dif8[7:0]};
        end
        res.flags = zalu_pkg::pack_flags(dif8[7], dif8[7:0] == 8'h00, a[4] ^ b[4] ^ dif8[4],
                                         (a[7] ^ b[7]) & (a[7] ^ dif8[7]), 1'b1, dif8[8]);
      end
      zalu_pkg::CMD_AND: begin
        r8        = a & b;
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::pack_flags(r8[7], r8 == 8'h00, 1'b1, ~^r8, 1'b0, 1'b0);
      end
      zalu_pkg::CMD_OR: begin
        r8        = a | b;
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, 1'b0);
      end
      zalu_pkg::CMD_XOR: begin
        r8        = a ^ b;
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, 1'b0);
      end
      zalu_pkg::CMD_INC: begin
        res.value = {8'h00, inc8};
        res.flags = zalu_pkg::pack_flags(inc8[7], inc8 == 8'h00, inc8[3:0] == 4'h0,
                                         inc8 == 8'h80, 1'b0, cin);
      end
      zalu_pkg::CMD_DEC: begin
        res.value = {8'h00, dec8};
        res.flags = zalu_pkg::pack_flags(dec8[7], dec8 == 8'h00, dec8[3:0] == 4'hf,
                                         dec8 == 8'h7f, 1'b1, cin);
      end
      zalu_pkg::CMD_RLCA: begin
        res.value = {8'h00, a[6:0], a[7]};
        res.flags = zalu_pkg::pack_flags(f[7], f[6], 1'b0, f[2], 1'b0, a[7]);
      end
      zalu_pkg::CMD_RLA: begin
        res.value = {8'h00, a[6:0], cin};
        res.flags = zalu_pkg::pack_flags(f[7], f[6], 1'b0, f[2], 1'b0, a[7]);
      end
      zalu_pkg::CMD_RRCA: begin
        res.value = {8'h00, a[0], a[7:1]};
        res.flags = zalu_pkg::pack_flags(f[7], f[6], 1'b0, f[2], 1'b0, a[0]);
      end
      zalu_pkg::CMD_RRA: begin
        res.value = {8'h00, cin, a[7:1]};
        res.flags = zalu_pkg::pack_flags(f[7], f[6], 1'b0, f[2], 1'b0, a[0]);
      end
      zalu_pkg::CMD_RLC: begin
        r8        = {a[6:0], a[7]};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[7]);
      end
      zalu_pkg::CMD_RL: begin
        r8        = {a[6:0], cin};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[7]);
      end
      zalu_pkg::CMD_RRC: begin
        r8        = {a[0], a[7:1]};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[0]);
      end
      zalu_pkg::CMD_RR: begin
        r8        = {cin, a[7:1]};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[0]);
      end
      zalu_pkg::CMD_SLA: begin
        r8        = {a[6:0], 1'b0};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[7]);
      end
      zalu_pkg::CMD_SRA: begin
        r8        = {a[7], a[7:1]};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[0]);
      end
      zalu_pkg::CMD_SRL: begin
        r8        = {1'b0, a[7:1]};
        res.value = {8'h00, r8};
        res.flags = zalu_pkg::shift_flags(r8, a[0]);
      end
      zalu_pkg::CMD_BIT: begin
        res.flags = zalu_pkg::pack_flags(f[7], ~a[req.bit_index], 1'b1, f[2], 1'b0, f[0]);
      end
      zalu_pkg::CMD_SET: begin
        res.value = {8'h00, a | mask8};
      end
      zalu_pkg::CMD_RES: begin
        res.value = {8'h00, a & ~mask8};
      end
      zalu_pkg::CMD_CPL: begin
        res.value = {8'h00, ~a};
        res.flags = zalu_pkg::pack_flags(f[7], f[6], 1'b1, f[2], 1'b1, f[0]);
      end
      zalu_pkg::CMD_ADD16: begin
        res.value = sum16[15:0];
        res.flags = zalu_pkg::pack_flags(f[7], f[6],
                                         req.operand_a[12] ^ req.operand_b[12] ^ sum16[12],
                                         f[2], 1'b0, sum16[16]);
      end
      zalu_pkg::CMD_SBC16: begin
        res.value = dif16[15:0];
        res.flags = zalu_pkg::pack_flags(dif16[15], dif16[15:0] == 16'h0000,
                                         req.operand_a[12] ^ req.operand_b[12] ^ dif16[12],
                                         (req.operand_a[15] ^ req.operand_b[15]) &
                                         (req.operand_a[15] ^ dif16[15]),
                                         1'b1, dif16[16]);
      end
      default: begin
        res.value = req.operand_a;
        res.flags = f;
      end
    endcase
  end

endmodule
`default_nettype wire
